FILE: rtl/bresenham_line_stepper_core_macros.svh
// Assertion macros shared by the line stepper RTL.
`ifndef BRESENHAM_LINE_STEPPER_CORE_MACROS_SVH
`define BRESENHAM_LINE_STEPPER_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define BLS_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`define BLS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define BLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BLS_ASSERT_NEVER(label, clk, rst_n, expr, msg)

`define BLS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)

`define BLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: rtl/bls_pkg.sv
// Types and constants of the line stepper.
package bls_pkg;

  localparam int COORD_BITS = 16;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [COORD_BITS-1:0] mag_t;
  typedef logic        [COORD_BITS:0]   tdelta_t;
  typedef logic        [COORD_BITS:0]   count_t;
  typedef logic signed [COORD_BITS+1:0] err_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t opcode;
    coord_t  x_start;
    coord_t  y_start;
    coord_t  x_end;
    coord_t  y_end;
  } in_item_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last;
  } out_item_t;

  // classified command handed from front to back
  typedef struct packed {
    logic    is_load;
    coord_t  x;
    coord_t  y;
    tdelta_t twice_dx;
    tdelta_t twice_dy;
    mag_t    major;
    logic    x_major;
    logic    x_down;
    logic    y_down;
  } cmd_t;

endpackage

FILE: rtl/bls_fifo.sv
// Small synchronous FIFO built from registers.
`include "bresenham_line_stepper_core_macros.svh"

module bls_fifo #(
  parameter type ITEM_T = logic,
  parameter int  DEPTH  = 2
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  ITEM_T push_data,
  output logic  full,
  input  logic  pop,
  output ITEM_T pop_data,
  output logic  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ITEM_T         mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push_ok, pop_ok;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign push_ok  = push && !full;
  assign pop_ok   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `BLS_ASSERT_NEVER(a_count_bound, clk, rst_n, count_r > CW'(DEPTH), "fifo count overflow")
  `BLS_ASSERT_NEXT(a_count_up, clk, rst_n, push_ok && !pop_ok, count_r == $past(count_r) + 1'b1, "fifo count did not rise")
  `BLS_ASSERT_NEXT(a_count_dn, clk, rst_n, pop_ok && !push_ok, count_r == $past(count_r) - 1'b1, "fifo count did not fall")

endmodule

FILE: rtl/bls_front.sv
// Front end: classifies items, works out deltas of loads, queues commands.
module bls_front #(
  parameter int CMD_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bls_pkg::in_item_t in_item,
  output logic              full,
  output logic              cmd_valid,
  output bls_pkg::cmd_t     cmd,
  input  logic              cmd_pop
);
  import bls_pkg::*;

  logic signed [COORD_BITS:0] dx_s, dy_s, dx_neg, dy_neg;
  mag_t  adx, ady;
  logic  x_major;
  cmd_t  cmd_in;
  logic  cmd_empty;

  always_comb begin
    dx_s   = {in_item.x_end[COORD_BITS-1], in_item.x_end}
           - {in_item.x_start[COORD_BITS-1], in_item.x_start};
    dy_s   = {in_item.y_end[COORD_BITS-1], in_item.y_end}
           - {in_item.y_start[COORD_BITS-1], in_item.y_start};
    dx_neg = -dx_s;
    dy_neg = -dy_s;
    adx    = dx_s[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx_s[COORD_BITS-1:0];
    ady    = dy_s[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy_s[COORD_BITS-1:0];
    // ties go to x
    x_major = (adx >= ady);

    cmd_in.is_load  = (in_item.opcode == OP_LOAD);
    cmd_in.x        = in_item.x_start;
    cmd_in.y        = in_item.y_start;
    cmd_in.twice_dx = {adx, 1'b0};
    cmd_in.twice_dy = {ady, 1'b0};
    cmd_in.major    = x_major ? adx : ady;
    cmd_in.x_major  = x_major;
    cmd_in.x_down   = dx_s[COORD_BITS];
    cmd_in.y_down   = dy_s[COORD_BITS];
  end

  bls_fifo #(
    .ITEM_T (cmd_t),
    .DEPTH  (CMD_DEPTH)
  ) u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (cmd_in),
    .full      (full),
    .pop       (cmd_pop),
    .pop_data  (cmd),
    .empty     (cmd_empty)
  );

  assign cmd_valid = !cmd_empty;

endmodule

FILE: rtl/bls_back.sv
// Back end: segment state, one pixel step per cycle while the result queue has room, result queue.
`include "bresenham_line_stepper_core_macros.svh"

module bls_back #(
  parameter int OUT_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  bls_pkg::cmd_t      cmd,
  output logic               cmd_pop,
  output logic               empty,
  input  logic               pop,
  output bls_pkg::out_item_t out_item
);
  import bls_pkg::*;

  coord_t  cur_x_r, cur_x_nxt;
  coord_t  cur_y_r, cur_y_nxt;
  err_t    err_r, err_nxt;
  tdelta_t tdx_r, tdx_nxt;
  tdelta_t tdy_r, tdy_nxt;
  count_t  left_r, left_nxt;
  logic    x_major_r, x_major_nxt;
  logic    x_down_r, x_down_nxt;
  logic    y_down_r, y_down_nxt;
  logic    active_r, active_nxt;

  err_t      major_d, minor_d, err_sub, err_fix;
  logic      minor_step, step_x, step_y, last;
  coord_t    x_stepped, y_stepped;
  logic      out_push, out_full;
  out_item_t out_data;

  always_comb begin
    major_d    = x_major_r ? err_t'({1'b0, tdx_r}) : err_t'({1'b0, tdy_r});
    minor_d    = x_major_r ? err_t'({1'b0, tdy_r}) : err_t'({1'b0, tdx_r});
    err_sub    = err_r - minor_d;
    err_fix    = err_sub + major_d;
    minor_step = err_sub[COORD_BITS+1];
    step_x     = x_major_r || minor_step;
    step_y     = !x_major_r || minor_step;
    // coordinates wrap past the end point; those values are never emitted
    x_stepped  = x_down_r ? cur_x_r - coord_t'(1) : cur_x_r + coord_t'(1);
    y_stepped  = y_down_r ? cur_y_r - coord_t'(1) : cur_y_r + coord_t'(1);
    last       = (left_r == count_t'(1));

    out_data.pixel_x = cur_x_r;
    out_data.pixel_y = cur_y_r;
    out_data.last    = last;
  end

  always_comb begin
    cur_x_nxt   = cur_x_r;
    cur_y_nxt   = cur_y_r;
    err_nxt     = err_r;
    tdx_nxt     = tdx_r;
    tdy_nxt     = tdy_r;
    left_nxt    = left_r;
    x_major_nxt = x_major_r;
    x_down_nxt  = x_down_r;
    y_down_nxt  = y_down_r;
    active_nxt  = active_r;
    cmd_pop     = 1'b0;
    out_push    = 1'b0;

    if (cmd_valid) begin
      if (cmd.is_load) begin
        cmd_pop     = 1'b1;
        cur_x_nxt   = cmd.x;
        cur_y_nxt   = cmd.y;
        err_nxt     = err_t'({2'b00, cmd.major});
        tdx_nxt     = cmd.twice_dx;
        tdy_nxt     = cmd.twice_dy;
        left_nxt    = count_t'({1'b0, cmd.major}) + 1'b1;
        x_major_nxt = cmd.x_major;
        x_down_nxt  = cmd.x_down;
        y_down_nxt  = cmd.y_down;
        active_nxt  = 1'b1;
      end else if (!active_r) begin
        // step with no segment: dropped
        cmd_pop = 1'b1;
      end else if (!out_full) begin
        cmd_pop    = 1'b1;
        out_push   = 1'b1;
        cur_x_nxt  = step_x ? x_stepped : cur_x_r;
        cur_y_nxt  = step_y ? y_stepped : cur_y_r;
        err_nxt    = minor_step ? err_fix : err_sub;
        left_nxt   = left_r - 1'b1;
        active_nxt = !last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r   <= '0;
      cur_y_r   <= '0;
      err_r     <= '0;
      tdx_r     <= '0;
      tdy_r     <= '0;
      left_r    <= '0;
      x_major_r <= 1'b0;
      x_down_r  <= 1'b0;
      y_down_r  <= 1'b0;
      active_r  <= 1'b0;
    end else begin
      cur_x_r   <= cur_x_nxt;
      cur_y_r   <= cur_y_nxt;
      err_r     <= err_nxt;
      tdx_r     <= tdx_nxt;
      tdy_r     <= tdy_nxt;
      left_r    <= left_nxt;
      x_major_r <= x_major_nxt;
      x_down_r  <= x_down_nxt;
      y_down_r  <= y_down_nxt;
      active_r  <= active_nxt;
    end
  end

  bls_fifo #(
    .ITEM_T (out_item_t),
    .DEPTH  (OUT_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (out_push),
    .push_data (out_data),
    .full      (out_full),
    .pop       (pop),
    .pop_data  (out_item),
    .empty     (empty)
  );

  `BLS_ASSERT_NEVER(a_active_left, clk, rst_n, active_r != (left_r != '0), "active flag and pixel count disagree")
  `BLS_ASSERT_IMPLIES(a_emit_active, clk, rst_n, out_push, active_r && !cmd.is_load, "pixel emitted without a segment")
  `BLS_ASSERT_NEXT(a_last_ends, clk, rst_n, out_push && last, !active_r, "segment still active after last pixel")

endmodule

FILE: rtl/bresenham_line_stepper_core.sv
// Line stepper top level: a load sets up a segment, each step in it returns one pixel.
// Path: a step goes into the command queue, then its pixel into the result queue.
// Throughput: one transaction per cycle on both sides unless a full queue stalls it;
// the back end's per-pixel error update (subtract, sign test, add back) is combinational.
// Reset: synchronous, active low; clears both queues and drops any active segment.
module bresenham_line_stepper_core #(
  parameter int CMD_DEPTH = 4,
  parameter int OUT_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  bls_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output bls_pkg::out_item_t out_item
);
  import bls_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  bls_front #(
    .CMD_DEPTH (CMD_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_item   (in_item),
    .full      (full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  bls_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

endmodule

FILE: dv/line_pixel_checker.sv
// Pixel checker for the line stepper: tracks segments and compares every popped pixel.
`timescale 1ns / 1ps

module line_pixel_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic               full,
  input  bls_pkg::in_item_t  in_item,
  input  logic               empty,
  input  logic               pop,
  input  bls_pkg::out_item_t out_item,
  output int                 mismatches,
  output int                 pixels_pending
);
  import bls_pkg::*;

  out_item_t pixel_q[$];

  // shadow of the stepper's segment state
  coord_t              pos_x;
  coord_t              pos_y;
  logic signed [18:0]  err;
  logic        [17:0]  two_dx;
  logic        [17:0]  two_dy;
  logic        [16:0]  left;
  logic                x_major;
  logic                x_down;
  logic                y_down;
  logic                seg_active;

  initial begin
    mismatches     = 0;
    pixels_pending = 0;
  end

  task automatic report(string msg);
    $display("%0t  mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic load_segment(in_item_t it);
    int dx;
    int dy;
    dx = int'(it.x_end) - int'(it.x_start);
    dy = int'(it.y_end) - int'(it.y_start);
    x_down = dx < 0;
    y_down = dy < 0;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    pos_x   = it.x_start;
    pos_y   = it.y_start;
    two_dx  = 18'(2 * dx);
    two_dy  = 18'(2 * dy);
    x_major = dx >= dy;
    err     = x_major ? 19'(dx) : 19'(dy);
    left    = x_major ? 17'(dx + 1) : 17'(dy + 1);
    seg_active = 1'b1;
  endtask

  task automatic step_segment();
    out_item_t want;
    if (!seg_active) return;
    want.pixel_x = pos_x;
    want.pixel_y = pos_y;
    want.last    = (left == 17'd1);
    pixel_q.push_back(want);
    if (x_major) begin
      pos_x = x_down ? pos_x - 1'b1 : pos_x + 1'b1;
      err   = err - $signed({1'b0, two_dy});
      if (err < 0) begin
        pos_y = y_down ? pos_y - 1'b1 : pos_y + 1'b1;
        err   = err + $signed({1'b0, two_dx});
      end
    end else begin
      pos_y = y_down ? pos_y - 1'b1 : pos_y + 1'b1;
      err   = err - $signed({1'b0, two_dx});
      if (err < 0) begin
        pos_x = x_down ? pos_x - 1'b1 : pos_x + 1'b1;
        err   = err + $signed({1'b0, two_dy});
      end
    end
    left = left - 1'b1;
    if (left == 0) seg_active = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pixel_q.delete();
      pos_x      = '0;
      pos_y      = '0;
      err        = '0;
      two_dx     = '0;
      two_dy     = '0;
      left       = '0;
      x_major    = 1'b0;
      x_down     = 1'b0;
      y_down     = 1'b0;
      seg_active = 1'b0;
    end else begin
      // outputs first: a pixel popped now never belongs to an item pushed now
      if (pop && !empty) begin
        if (pixel_q.size() == 0) begin
          report($sformatf("pixel (%0d,%0d) last=%0b with nothing expected",
                           out_item.pixel_x, out_item.pixel_y, out_item.last));
        end else begin
          if (out_item.pixel_x !== pixel_q[0].pixel_x)
            report($sformatf("pixel_x got %0d expected %0d",
                             out_item.pixel_x, pixel_q[0].pixel_x));
          if (out_item.pixel_y !== pixel_q[0].pixel_y)
            report($sformatf("pixel_y got %0d expected %0d",
                             out_item.pixel_y, pixel_q[0].pixel_y));
          if (out_item.last !== pixel_q[0].last)
            report($sformatf("last got %b expected %b at (%0d,%0d)", out_item.last,
                             pixel_q[0].last, pixel_q[0].pixel_x, pixel_q[0].pixel_y));
          void'(pixel_q.pop_front());
        end
      end
      if (push && !full) begin
        if (in_item.opcode == OP_LOAD) load_segment(in_item);
        else step_segment();
      end
    end
    pixels_pending = pixel_q.size();
  end

endmodule

FILE: dv/testbench.sv
// Testbench top for the line stepper: stimulus, idling and the verdict.
`timescale 1ns / 1ps

module testbench;
  import bls_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      push = 1'b0;
  logic      full;
  in_item_t  in_item = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t out_item;

  int mismatches;
  int pixels_pending;

  int send_idle = 0;
  int recv_idle = 0;
  int seg_left  = 0;   // pixels the current segment can still give
  int counted   = 0;   // transactions that load or yield a pixel

  always #5 clk = ~clk;

  bresenham_line_stepper_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  line_pixel_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_item        (in_item),
    .empty          (empty),
    .pop            (pop),
    .out_item       (out_item),
    .mismatches     (mismatches),
    .pixels_pending (pixels_pending)
  );

  always @(negedge clk) begin
    pop <= rst_n && ($urandom_range(99) >= recv_idle);
  end

  initial begin
    #2_000_000;
    $display("testbench: errors");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send(in_item_t it);
    int dx;
    int dy;
    while ($urandom_range(99) < send_idle) begin
      push = 1'b0;
      @(negedge clk);
    end
    push    = 1'b1;
    in_item = it;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    if (it.opcode == OP_LOAD) begin
      dx = int'(it.x_end) - int'(it.x_start);
      dy = int'(it.y_end) - int'(it.y_start);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      seg_left = ((dx >= dy) ? dx : dy) + 1;
      counted++;
    end else if (seg_left > 0) begin
      seg_left--;
      counted++;
    end
  endtask

  task automatic drain();
    push = 1'b0;
    wait (pixels_pending == 0);
    @(negedge clk);
  endtask

  function automatic in_item_t step_item();
    in_item_t it;
    it.opcode  = OP_STEP;
    it.x_start = coord_t'($urandom);
    it.y_start = coord_t'($urandom);
    it.x_end   = coord_t'($urandom);
    it.y_end   = coord_t'($urandom);
    return it;
  endfunction

  task automatic load_seg(int xs, int ys, int xe, int ye);
    in_item_t it;
    it.opcode  = OP_LOAD;
    it.x_start = coord_t'(xs);
    it.y_start = coord_t'(ys);
    it.x_end   = coord_t'(xe);
    it.y_end   = coord_t'(ye);
    send(it);
  endtask

  task automatic steps(int n);
    repeat (n) send(step_item());
  endtask

  // end point near a start point without leaving the coordinate range
  function automatic int near(int c, int d);
    int v;
    v = c + d;
    if (v > 32767 || v < -32768) v = c - d;
    return v;
  endfunction

  task automatic random_segment();
    int r;
    int span;
    int xs;
    int ys;
    int n;
    r    = $urandom_range(99);
    span = ($urandom_range(9) == 0) ? 400 : 12;
    xs   = int'(coord_t'($urandom));
    ys   = int'(coord_t'($urandom));
    if (r >= 92) begin
      // noise: arbitrary end points, a few steps, then replaced
      load_seg(xs, ys, int'(coord_t'($urandom)), int'(coord_t'($urandom)));
      n = $urandom_range(6);
    end else begin
      load_seg(xs, ys,
               near(xs, $urandom_range(span) * ($urandom_range(1) ? 1 : -1)),
               near(ys, $urandom_range(span) * ($urandom_range(1) ? 1 : -1)));
      if (r < 80) n = seg_left + $urandom_range(2);
      else n = $urandom_range(seg_left - 1);
    end
    steps(n);
  endtask

  task automatic run_phase(int s_idle, int r_idle, int target);
    send_idle = s_idle;
    recv_idle = r_idle;
    while (counted < target) random_segment();
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_idle = 27;
    recv_idle = 46;
    steps(1);                                   // nothing loaded yet
    load_seg(5, -3, 5, -3);                     // single pixel segment
    steps(2);
    load_seg(-32768, -32768, 32767, 32767);     // widest tie, x major
    steps(2);
    load_seg(32767, -32768, -32768, 32767);     // replaces mid-segment
    steps(2);
    load_seg(0, 0, 1, 3);                       // steep, y major
    steps(4);
    load_seg(2, 1, -1, -1);                     // both axes stepping down
    steps(4);
    load_seg(32767, 32767, 32767, 32767);       // position wraps after the pixel
    steps(2);
    drain();

    run_phase(27, 46, 600);
    run_phase(46, 27, 1150);
    run_phase(0, 0, 1700);

    push = 1'b0;
    wait (pixels_pending == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
